/* hw/rtl/llqc_pkg.sv */
`default_nettype none
package llqc_pkg;

  // Fixed geometry of the block
  localparam int NUM_BUCKETS = 6;
  localparam int NUM_LEVELS  = 4;
  localparam int BKT_W       = $clog2(NUM_BUCKETS);
  localparam int LVL_W       = $clog2(NUM_LEVELS);

  // Field widths
  localparam int COUNT_W   = 16;
  localparam int WEIGHT_W  = 8;
  localparam int THR_W     = 7;
  localparam int SUM_W     = 27;
  localparam int QUAL_W    = 14;
  localparam int LCNT_W    = 32;
  localparam int DVD_W     = 30;
  localparam int HUND_W    = 23;
  localparam int MUL_W     = SUM_W + WEIGHT_W;
  localparam int DCNT_W    = $clog2(DVD_W);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = WEIGHT_W * NUM_BUCKETS;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR0    = 3'd1;

  // Command codes
  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Constants
  localparam logic [QUAL_W-1:0]    FULL_SCALE    = 14'd10000;
  localparam logic [THR_W-1:0]     PCT_MAX       = 7'd100;
  localparam logic [CFG_DAT_W-1:0] WEIGHTS_RESET = 48'h6414_0A05_0201;

  typedef logic [THR_W-1:0] thr_t;
  typedef thr_t [NUM_LEVELS-1:0] thr_arr_t;

  localparam thr_arr_t THR_RESET = {7'd98, 7'd96, 7'd94, 7'd0};

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MAC  = 5'b00010,
    ST_LVL  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

endpackage
`default_nettype wire

/* hw/rtl/latency_link_quality_classifier.sv */
// Latency link quality classifier.
// Input channel (in_valid / in_stall): one word carries a command and six
// latency-bucket message counts. A latency event forms the weighted count sum,
// the quality floor(10000*N1/sum) saturated at 10000, and bumps the saturating
// counter of the highest level whose percent threshold is met. A clear word
// zeroes all level counters.
// Output channel (out_valid / out_stall): one result word per input word with
// quality, level hit and all four counters after the update.
// Processing: an event runs one multiply-accumulate per bucket on the shared
// 27x8 multiplier, up to 4 threshold compares on the same multiplier, the
// bit-serial restoring divider (skipped when N1 or the sum is zero) and the
// output step. A clear word goes straight to the output step.
// One word is worked on at a time; in_stall is high from accept until the
// result is moved into the output register.
// The output register holds its word while out_stall is high; the next input
// word may be accepted and processed meanwhile, and waits in the final step.
// Reset (rst_n low, synchronous) restores default weights and thresholds,
// zeroes the counters and empties the output register.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
`default_nettype none
module latency_link_quality_classifier (
  input  wire                                           clk,
  input  wire                                           rst_n,
  input  wire                                           cfg_we,
  input  wire  [llqc_pkg::CFG_IDX_W-1:0]                cfg_index,
  input  wire  [llqc_pkg::CFG_DAT_W-1:0]                cfg_data,
  input  wire                                           in_valid,
  output logic                                          in_stall,
  input  wire                                           in_cmd,
  input  wire  [llqc_pkg::COUNT_W-1:0]                  in_count_bucket_1,
  input  wire  [llqc_pkg::COUNT_W-1:0]                  in_count_bucket_2,
  input  wire  [llqc_pkg::COUNT_W-1:0]                  in_count_bucket_3,
  input  wire  [llqc_pkg::COUNT_W-1:0]                  in_count_bucket_4,
  input  wire  [llqc_pkg::COUNT_W-1:0]                  in_count_bucket_5,
  input  wire  [llqc_pkg::COUNT_W-1:0]                  in_count_bucket_6,
  output logic                                          out_valid,
  input  wire                                           out_stall,
  output logic [llqc_pkg::QUAL_W-1:0]                   out_quality_centi,
  output logic                                          out_level_found,
  output logic [llqc_pkg::LVL_W-1:0]                    out_level_hit,
  output logic [llqc_pkg::LCNT_W-1:0]                   out_level_count_0,
  output logic [llqc_pkg::LCNT_W-1:0]                   out_level_count_1,
  output logic [llqc_pkg::LCNT_W-1:0]                   out_level_count_2,
  output logic [llqc_pkg::LCNT_W-1:0]                   out_level_count_3
);

  localparam int NB = llqc_pkg::NUM_BUCKETS;
  localparam int NL = llqc_pkg::NUM_LEVELS;

  // Configuration
  logic [llqc_pkg::CFG_DAT_W-1:0] weights_r;
  llqc_pkg::thr_arr_t             thr_r;
  logic [llqc_pkg::CFG_IDX_W-1:0] thr_sel;

  // Sequencer and datapath registers
  llqc_pkg::state_t                state_r, state_nxt;
  logic [llqc_pkg::COUNT_W-1:0]    cnt_r [NB];
  logic                            clr_r;
  logic [llqc_pkg::BKT_W-1:0]      bkt_r;
  logic [llqc_pkg::LVL_W-1:0]      lvl_r;
  logic [llqc_pkg::DCNT_W-1:0]     dcnt_r;
  logic [llqc_pkg::SUM_W-1:0]      sum_r;
  logic [llqc_pkg::SUM_W-1:0]      rem_r;
  logic [llqc_pkg::DVD_W-1:0]      dvd_r;
  logic                            found_r;
  logic [llqc_pkg::LVL_W-1:0]      hit_r;
  logic [llqc_pkg::LCNT_W-1:0]     lcnt_r [NL];
  logic                            out_valid_r;

  // Shared multiplier and helpers
  logic [llqc_pkg::SUM_W-1:0]      mul_a;
  logic [llqc_pkg::WEIGHT_W-1:0]   mul_b;
  logic [llqc_pkg::MUL_W-1:0]      mul_p;
  logic [llqc_pkg::HUND_W-1:0]     hund_n1;
  logic                            n1_zero;
  logic                            sum_zero;
  logic                            met;
  logic [llqc_pkg::THR_W-1:0]      thr_cur;
  logic [llqc_pkg::SUM_W:0]        rem_sh;
  logic                            qbit;
  logic [llqc_pkg::QUAL_W-1:0]     qual;
  logic                            in_acc;
  logic                            out_free;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != llqc_pkg::ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // Write configuration registers
  assign thr_sel = cfg_index - llqc_pkg::REG_THR0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weights_r <= llqc_pkg::WEIGHTS_RESET;
      thr_r     <= llqc_pkg::THR_RESET;
    end else if (cfg_we) begin
      if (cfg_index == llqc_pkg::REG_WEIGHTS) begin
        weights_r <= cfg_data;
      end else if (cfg_index >= llqc_pkg::REG_THR0 &&
                   thr_sel < llqc_pkg::CFG_IDX_W'(NL)) begin
        thr_r[thr_sel[llqc_pkg::LVL_W-1:0]] <= cfg_data[llqc_pkg::THR_W-1:0];
      end
    end
  end

  // Status flags of the current word
  assign n1_zero  = (cnt_r[0] == '0);
  assign sum_zero = (sum_r == '0);
  assign hund_n1  = llqc_pkg::HUND_W'(cnt_r[0]) * llqc_pkg::HUND_W'(100);
  assign thr_cur  = thr_r[lvl_r];

  // Share one multiplier between the weighted sum and the threshold compare
  always_comb begin
    if (state_r == llqc_pkg::ST_LVL) begin
      mul_a = sum_r;
      mul_b = llqc_pkg::WEIGHT_W'(thr_cur);
    end else begin
      mul_a = llqc_pkg::SUM_W'(cnt_r[bkt_r]);
      mul_b = weights_r[bkt_r*llqc_pkg::WEIGHT_W +: llqc_pkg::WEIGHT_W];
    end
    mul_p = llqc_pkg::MUL_W'(mul_a) * llqc_pkg::MUL_W'(mul_b);
  end

  // Level test, with the empty first bucket and zero sum handled apart
  always_comb begin
    if (n1_zero) begin
      met = (thr_cur == '0);
    end else if (sum_zero) begin
      met = (thr_cur <= llqc_pkg::PCT_MAX);
    end else begin
      met = (llqc_pkg::MUL_W'(hund_n1) >= mul_p);
    end
  end

  // Restoring divider step: one quotient bit per cycle
  assign rem_sh = {rem_r, dvd_r[llqc_pkg::DVD_W-1]};
  assign qbit   = (rem_sh >= {1'b0, sum_r});

  // Saturate quality
  always_comb begin
    if (clr_r || n1_zero) begin
      qual = '0;
    end else if (sum_zero || dvd_r > llqc_pkg::DVD_W'(llqc_pkg::FULL_SCALE)) begin
      qual = llqc_pkg::FULL_SCALE;
    end else begin
      qual = dvd_r[llqc_pkg::QUAL_W-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      llqc_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_cmd == llqc_pkg::CMD_CLEAR) ? llqc_pkg::ST_OUT
                                                     : llqc_pkg::ST_MAC;
        end
      end
      llqc_pkg::ST_MAC: begin
        if (bkt_r == llqc_pkg::BKT_W'(NB - 1)) begin
          state_nxt = llqc_pkg::ST_LVL;
        end
      end
      llqc_pkg::ST_LVL: begin
        if (met || lvl_r == '0) begin
          state_nxt = (n1_zero || sum_zero) ? llqc_pkg::ST_OUT : llqc_pkg::ST_DIV;
        end
      end
      llqc_pkg::ST_DIV: begin
        if (dcnt_r == '0) begin
          state_nxt = llqc_pkg::ST_OUT;
        end
      end
      llqc_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = llqc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = llqc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= llqc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath: capture word, accumulate, step the levels, divide
  always_ff @(posedge clk) begin
    case (state_r)
      llqc_pkg::ST_IDLE: begin
        if (in_acc) begin
          cnt_r[0] <= in_count_bucket_1;
          cnt_r[1] <= in_count_bucket_2;
          cnt_r[2] <= in_count_bucket_3;
          cnt_r[3] <= in_count_bucket_4;
          cnt_r[4] <= in_count_bucket_5;
          cnt_r[5] <= in_count_bucket_6;
          clr_r    <= (in_cmd == llqc_pkg::CMD_CLEAR);
          bkt_r    <= '0;
          lvl_r    <= llqc_pkg::LVL_W'(NL - 1);
          sum_r    <= '0;
          found_r  <= 1'b0;
          hit_r    <= '0;
        end
      end
      llqc_pkg::ST_MAC: begin
        sum_r <= sum_r + llqc_pkg::SUM_W'(mul_p);
        bkt_r <= bkt_r + 1'b1;
      end
      llqc_pkg::ST_LVL: begin
        if (met) begin
          found_r <= 1'b1;
          hit_r   <= lvl_r;
        end else if (lvl_r != '0) begin
          lvl_r <= lvl_r - 1'b1;
        end
        // Preload the divider
        rem_r  <= '0;
        dvd_r  <= llqc_pkg::DVD_W'(cnt_r[0]) *
                  llqc_pkg::DVD_W'(llqc_pkg::FULL_SCALE);
        dcnt_r <= llqc_pkg::DCNT_W'(llqc_pkg::DVD_W - 1);
      end
      llqc_pkg::ST_DIV: begin
        rem_r  <= qbit ? llqc_pkg::SUM_W'(rem_sh - {1'b0, sum_r})
                       : llqc_pkg::SUM_W'(rem_sh);
        dvd_r  <= {dvd_r[llqc_pkg::DVD_W-2:0], qbit};
        dcnt_r <= dcnt_r - 1'b1;
      end
      default: ;
    endcase
  end

  // Level counters: clear on command, saturating increment on hit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NL; k++) lcnt_r[k] <= '0;
    end else if (state_r == llqc_pkg::ST_IDLE && in_acc &&
                 in_cmd == llqc_pkg::CMD_CLEAR) begin
      for (int k = 0; k < NL; k++) lcnt_r[k] <= '0;
    end else if (state_r == llqc_pkg::ST_LVL && met &&
                 lcnt_r[lvl_r] != '1) begin
      lcnt_r[lvl_r] <= lcnt_r[lvl_r] + 1'b1;
    end
  end

  // Output register: load in the final step, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == llqc_pkg::ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == llqc_pkg::ST_OUT && out_free) begin
      out_quality_centi <= qual;
      out_level_found   <= found_r;
      out_level_hit     <= hit_r;
      out_level_count_0 <= lcnt_r[0];
      out_level_count_1 <= lcnt_r[1];
      out_level_count_2 <= lcnt_r[2];
      out_level_count_3 <= lcnt_r[3];
    end
  end

endmodule
`default_nettype wire
